FILE: sv/abip_pkg.sv
// Shared types, codes and helpers for the auto-base integer parser.
// No dependencies; used by abip_step, abip_out_buf, the top level and the testbench.

package abip_pkg;

	localparam int unsigned ValueW = 64;
	localparam int unsigned CountW = 16;
	localparam int unsigned WideW  = ValueW + 4;

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChSeven = 8'h37;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChLowX  = 8'h78;
	localparam logic [7:0] ChUpX   = 8'h58;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowF  = 8'h66;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpF   = 8'h46;

	localparam logic [WideW-1:0] PosLimit = {5'd0, {(ValueW-1){1'b1}}};
	localparam logic [WideW-1:0] NegLimit = {4'd0, 1'b1, {(ValueW-1){1'b0}}};
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ZERO   = 2'd1,
		PH_DIGITS = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} base_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       begin_string;
	} char_item_t;

	typedef struct packed {
		logic signed [ValueW-1:0] parsed_value;
		logic                     overflowed;
		logic [CountW-1:0]        chars_consumed;
	} res_item_t;

	typedef struct packed {
		phase_t              phase;
		base_t               base;
		logic                negative;
		logic [ValueW-1:0]   magnitude;
		logic                overflow;
		logic [CountW-1:0]   count;
	} parse_state_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	function automatic digit_t digit_of(input logic [7:0] c, input base_t base);
		digit_t d;
		d.ok  = 1'b0;
		d.val = 4'd0;
		unique case (base)
			BASE_HEX: begin
				if (c >= ChZero && c <= ChNine) begin
					d.ok  = 1'b1;
					d.val = c[3:0];
				end else if ((c >= ChLowA && c <= ChLowF) || (c >= ChUpA && c <= ChUpF)) begin
					d.ok  = 1'b1;
					d.val = c[3:0] + 4'd9;
				end
			end
			BASE_OCT: begin
				if (c >= ChZero && c <= ChSeven) begin
					d.ok  = 1'b1;
					d.val = c[3:0];
				end
			end
			default: begin
				if (c >= ChZero && c <= ChNine) begin
					d.ok  = 1'b1;
					d.val = c[3:0];
				end
			end
		endcase
		return d;
	endfunction

	function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] n);
		return (n == CountMax) ? n : n + CountW'(1);
	endfunction

endpackage

FILE: sv/abip_step.sv
// Next-state and result logic for one character of the parser.
// Depends on abip_pkg.

module abip_step (
	input  abip_pkg::parse_state_t cur,
	input  abip_pkg::char_item_t   item,
	output abip_pkg::parse_state_t nxt,
	output logic                   res_valid,
	output abip_pkg::res_item_t    res
);

	abip_pkg::parse_state_t         work;
	logic                           do_digit;
	abip_pkg::digit_t               dig;
	logic [abip_pkg::WideW-1:0]     prod;
	logic [abip_pkg::WideW-1:0]     sum;
	logic [abip_pkg::WideW-1:0]     limit;
	logic [abip_pkg::ValueW-1:0]    mag_ext;

	always_comb begin
		work     = cur;
		do_digit = 1'b0;
		if (item.begin_string) begin
			work.base      = abip_pkg::BASE_DEC;
			work.negative  = 1'b0;
			work.magnitude = '0;
			work.overflow  = 1'b0;
			work.count     = '0;
			work.phase     = abip_pkg::PH_DIGITS;
			if (item.char_code == abip_pkg::ChZero) begin
				work.count = abip_pkg::CountW'(1);
				work.phase = abip_pkg::PH_ZERO;
			end else if (item.char_code == abip_pkg::ChMinus) begin
				work.count    = abip_pkg::CountW'(1);
				work.negative = 1'b1;
			end else begin
				do_digit = 1'b1;
			end
		end else begin
			case (cur.phase)
				abip_pkg::PH_ZERO: begin
					work.phase = abip_pkg::PH_DIGITS;
					if (item.char_code == abip_pkg::ChLowX || item.char_code == abip_pkg::ChUpX) begin
						work.base  = abip_pkg::BASE_HEX;
						work.count = abip_pkg::sat_inc(cur.count);
					end else begin
						work.base = abip_pkg::BASE_OCT;
						do_digit  = 1'b1;
					end
				end
				abip_pkg::PH_DIGITS: do_digit = 1'b1;
				default: do_digit = 1'b0;
			endcase
		end
	end

	always_comb begin
		dig = abip_pkg::digit_of(item.char_code, work.base);
		case (work.base)
			abip_pkg::BASE_HEX: prod = {work.magnitude, 4'd0};
			abip_pkg::BASE_OCT: prod = {1'b0, work.magnitude, 3'd0};
			default: prod = {3'd0, work.magnitude, 1'b0} + {1'b0, work.magnitude, 3'd0};
		endcase
		sum     = prod + abip_pkg::WideW'(dig.val);
		limit   = work.negative ? abip_pkg::NegLimit : abip_pkg::PosLimit;
		mag_ext = work.negative ? (~work.magnitude + abip_pkg::ValueW'(1)) : work.magnitude;
	end

	always_comb begin
		nxt       = work;
		res_valid = 1'b0;
		res       = '0;
		if (do_digit) begin
			if (!dig.ok) begin
				res_valid          = 1'b1;
				res.parsed_value   = mag_ext;
				res.overflowed     = work.overflow;
				res.chars_consumed = work.count;
				nxt.phase          = abip_pkg::PH_IDLE;
			end else begin
				nxt.magnitude = sum[abip_pkg::ValueW-1:0];
				nxt.overflow  = work.overflow | (sum > limit);
				nxt.count     = abip_pkg::sat_inc(work.count);
			end
		end
	end

endmodule

FILE: sv/abip_out_buf.sv
// Two-entry result buffer: an output register plus one spare entry.
// Depends on abip_pkg.

module abip_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  abip_pkg::res_item_t push_item,
	output logic                room,
	output logic                res_valid,
	input  logic                res_ready,
	output abip_pkg::res_item_t res_item
);

	logic                head_valid_q;
	abip_pkg::res_item_t head_q;
	logic                spare_valid_q;
	abip_pkg::res_item_t spare_q;
	logic                pop;

	assign pop       = head_valid_q && res_ready;
	assign room      = !spare_valid_q;
	assign res_valid = head_valid_q;
	assign res_item  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q  <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			if (pop && spare_valid_q) begin
				head_valid_q  <= 1'b1;
				spare_valid_q <= push;
			end else if (pop || !head_valid_q) begin
				head_valid_q <= push;
			end else if (push) begin
				spare_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && spare_valid_q) begin
			head_q  <= spare_q;
			spare_q <= push_item;
		end else if (pop || !head_valid_q) begin
			head_q <= push_item;
		end else if (push) begin
			spare_q <= push_item;
		end
	end

endmodule

FILE: sv/auto_base_integer_parser.sv
// Top level of the auto-base signed integer parser: parse state and result buffer.
// Depends on abip_pkg, abip_step and abip_out_buf.
//
//   channel | signals                              | direction
//   char    | char_valid, char_ready, char_item    | in, one byte per item
//   res     | res_valid, res_ready, res_item       | out, at most one per string
//
// One character per cycle while char_ready is high; the state register closes
// the loop through one step of shift-add accumulate and overflow compare.
// A result appears at res in the cycle after its terminating character is taken,
// or later when an earlier result still waits unread.
// char_ready drops only when two results wait unread.
// Reset returns the parser to idle and empties the result buffer.

module auto_base_integer_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_ready,
	input  abip_pkg::char_item_t char_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output abip_pkg::res_item_t  res_item
);

	abip_pkg::parse_state_t state_q;
	abip_pkg::parse_state_t state_nxt;
	logic                   step_res_valid;
	abip_pkg::res_item_t    step_res;
	logic                   accept;
	logic                   room;

	assign char_ready = room;
	assign accept     = char_valid && room;

	abip_step u_step (
		.cur       (state_q),
		.item      (char_item),
		.nxt       (state_nxt),
		.res_valid (step_res_valid),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= abip_pkg::PH_IDLE;
			state_q.base      <= abip_pkg::BASE_DEC;
			state_q.negative  <= 1'b0;
			state_q.magnitude <= '0;
			state_q.overflow  <= 1'b0;
			state_q.count     <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	abip_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && step_res_valid),
		.push_item (step_res),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

FILE: verif/auto_base_integer_parser_tb.sv
// Self-checking testbench for auto_base_integer_parser: streams strings one character per item
// and checks every parse result against an in-bench predictor of the parser.
// Depends on abip_pkg and the auto_base_integer_parser RTL.
`timescale 1ns / 100ps

module auto_base_integer_parser_tb;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 char_valid = 1'b0;
	logic                 char_ready;
	abip_pkg::char_item_t char_item = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	abip_pkg::res_item_t  res_item;

	abip_pkg::char_item_t pending_chars[$];
	abip_pkg::res_item_t  expected_results[$];
	int                   error_count = 0;
	bit                   char_taken = 1'b0;
	int                   char_gap = 0;
	int                   res_gap = 0;

	abip_pkg::phase_t cur_phase = abip_pkg::PH_IDLE;
	abip_pkg::base_t  cur_base = abip_pkg::BASE_DEC;
	logic             cur_neg = 1'b0;
	logic [63:0]      cur_mag = '0;
	logic             cur_ovf = 1'b0;
	logic [15:0]      cur_count = '0;

	auto_base_integer_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int char_digit(input logic [7:0] c, input abip_pkg::base_t b);
		if (c >= abip_pkg::ChZero && c <= abip_pkg::ChNine &&
			(b != abip_pkg::BASE_OCT || c <= abip_pkg::ChSeven))
			return int'(c - abip_pkg::ChZero);
		if (b == abip_pkg::BASE_HEX && c >= abip_pkg::ChLowA && c <= abip_pkg::ChLowF)
			return int'(c - abip_pkg::ChLowA) + 10;
		if (b == abip_pkg::BASE_HEX && c >= abip_pkg::ChUpA && c <= abip_pkg::ChUpF)
			return int'(c - abip_pkg::ChUpA) + 10;
		return -1;
	endfunction

	task automatic bump_count();
		if (cur_count != 16'hFFFF)
			cur_count = cur_count + 16'd1;
	endtask

	task automatic parse_char(input abip_pkg::char_item_t it, output bit has_res,
		output abip_pkg::res_item_t res);
		logic [7:0]  c;
		logic [63:0] radix;
		logic [63:0] lim;
		logic [63:0] dig;
		int          dv;
		bit          take;
		c = it.char_code;
		has_res = 1'b0;
		res = '0;
		take = 1'b1;
		if (it.begin_string) begin
			cur_base = abip_pkg::BASE_DEC;
			cur_neg = 1'b0;
			cur_mag = '0;
			cur_ovf = 1'b0;
			cur_count = '0;
			cur_phase = abip_pkg::PH_DIGITS;
			if (c == abip_pkg::ChZero) begin
				cur_count = 16'd1;
				cur_phase = abip_pkg::PH_ZERO;
				take = 1'b0;
			end else if (c == abip_pkg::ChMinus) begin
				cur_count = 16'd1;
				cur_neg = 1'b1;
				take = 1'b0;
			end
		end else if (cur_phase == abip_pkg::PH_ZERO) begin
			cur_phase = abip_pkg::PH_DIGITS;
			if (c == abip_pkg::ChLowX || c == abip_pkg::ChUpX) begin
				cur_base = abip_pkg::BASE_HEX;
				bump_count();
				take = 1'b0;
			end else begin
				cur_base = abip_pkg::BASE_OCT;
			end
		end else if (cur_phase != abip_pkg::PH_DIGITS) begin
			take = 1'b0;
		end
		if (take) begin
			radix = (cur_base == abip_pkg::BASE_HEX) ? 64'd16 :
				(cur_base == abip_pkg::BASE_OCT) ? 64'd8 : 64'd10;
			dv = char_digit(c, cur_base);
			if (dv < 0) begin
				has_res = 1'b1;
				res.parsed_value = cur_neg ? -cur_mag : cur_mag;
				res.overflowed = cur_ovf;
				res.chars_consumed = cur_count;
				cur_phase = abip_pkg::PH_IDLE;
			end else begin
				dig = 64'(dv);
				if (!cur_ovf) begin
					lim = cur_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
					if (cur_mag > (lim - dig) / radix)
						cur_ovf = 1'b1;
				end
				cur_mag = cur_mag * radix + dig;
				bump_count();
			end
		end
	endtask

	task automatic push_char(input logic [7:0] c, input bit b);
		abip_pkg::char_item_t it;
		it.char_code = c;
		it.begin_string = b;
		pending_chars.push_back(it);
	endtask

	task automatic push_text(input string s, input bit b);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], b && i == 0);
	endtask

	task automatic push_random_bytes(input int n, input bit first_begin);
		for (int i = 0; i < n; i++)
			push_char(8'($urandom_range(0, 255)), first_begin && i == 0);
	endtask

	task automatic queue_number();
		logic [63:0]     mag;
		abip_pkg::base_t nb;
		bit              neg;
		string           text;
		string           digits;
		byte             ch;
		int              k;
		nb = abip_pkg::base_t'($urandom_range(0, 2));
		neg = (nb == abip_pkg::BASE_DEC) && $urandom_range(0, 1);
		k = $urandom_range(0, 4);
		case (k)
			0: mag = 64'($urandom_range(0, 999));
			1: mag = {$urandom, $urandom};
			2: mag = 64'h7FFF_FFFF_FFFF_FFFE + 64'($urandom_range(0, 3));
			3: mag = 64'hFFFF_FFFF_FFFF_FFFF;
			default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
		text = neg ? "-" : "";
		if (nb == abip_pkg::BASE_OCT)
			text = "0";
		else if (nb == abip_pkg::BASE_HEX)
			text = $urandom_range(0, 1) ? "0x" : "0X";
		if (nb != abip_pkg::BASE_DEC || neg)
			repeat ($urandom_range(0, 2)) text = {text, "0"};
		case (nb)
			abip_pkg::BASE_OCT: digits = $sformatf("%0o", mag);
			abip_pkg::BASE_HEX: digits = $sformatf("%0h", mag);
			default:  digits = $sformatf("%0d", mag);
		endcase
		for (int i = 0; i < digits.len(); i++) begin
			ch = digits[i];
			if (ch >= abip_pkg::ChLowA && ch <= abip_pkg::ChLowF && $urandom_range(0, 1))
				digits[i] = ch - 8'd32;
		end
		text = {text, digits};
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				case (nb)
					abip_pkg::BASE_OCT: digits = $sformatf("%0d", $urandom_range(0, 7));
					abip_pkg::BASE_HEX: digits = $sformatf("%0h", $urandom_range(0, 15));
					default:  digits = $sformatf("%0d", $urandom_range(0, 9));
				endcase
				text = {text, digits};
			end
		end
		push_text(text, 1'b1);
		case ($urandom_range(0, 3))
			0: push_char(8'h00, 1'b0);
			1: push_random_bytes(1, 1'b0);
			2: push_text($urandom_range(0, 1) ? "g" : " ", 1'b0);
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0)
			push_random_bytes($urandom_range(1, 3), 1'b0);
	endtask

	task automatic queue_broken();
		case ($urandom_range(0, 4))
			0: push_text("0", 1'b1);
			1: push_text("0x", 1'b1);
			2: push_text("0X", 1'b1);
			3: push_text("-", 1'b1);
			default: push_text("-0", 1'b1);
		endcase
		push_random_bytes($urandom_range(0, 2), 1'b0);
	endtask

	initial begin
		int target;
		// empty and lone prefixes, sign before a hex prefix, octal end, restart, idle bytes
		push_char(8'h00, 1'b1);
		push_text("0", 1'b1);
		push_char(8'h00, 1'b0);
		push_text("0xg", 1'b1);
		push_text("-a", 1'b1);
		push_text("-0x", 1'b1);
		push_text("0Xf", 1'b1);
		push_char(8'h00, 1'b0);
		push_text("078", 1'b1);
		push_text("12", 1'b1);
		push_text("3", 1'b1);
		push_char(8'h00, 1'b0);
		push_text("z", 1'b0);
		push_char(8'hFF, 1'b0);
		push_char(8'hFF, 1'b1);
		target = 850;
		while (pending_chars.size() < target) begin
			case ($urandom_range(0, 99)) inside
				[0:74]:  queue_number();
				[75:86]: queue_broken();
				default: push_random_bytes($urandom_range(1, 6), $urandom_range(0, 1));
			endcase
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_chars.size() != 0 || char_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS auto_base_integer_parser");
		end else begin
			$display("FAIL auto_base_integer_parser");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL auto_base_integer_parser");
		$finish;
	end

	always @(negedge clk) begin
		logic                 next_valid;
		abip_pkg::char_item_t next_item;
		bit                   quiet_tail;
		if (arst_n) begin
			quiet_tail = pending_chars.size() < 200;
			next_valid = char_valid && !char_taken;
			next_item = char_item;
			if (!next_valid) begin
				if (char_gap != 0) begin
					char_gap--;
				end else if (pending_chars.size() != 0) begin
					next_item = pending_chars.pop_front();
					next_valid = 1'b1;
					if (!quiet_tail && $urandom_range(0, 7) == 0)
						char_gap = $urandom_range(1, 16);
				end
			end
			char_valid <= next_valid;
			char_item <= next_item;
			if (res_gap != 0) begin
				res_gap--;
				res_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
				res_gap = $urandom_range(1, 16) - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		bit                  got;
		abip_pkg::res_item_t predicted;
		abip_pkg::res_item_t oldest;
		char_taken = 1'b0;
		if (arst_n) begin
			char_taken = char_valid && char_ready;
			if (char_taken) begin
				parse_char(char_item, got, predicted);
				if (got)
					expected_results.push_back(predicted);
			end
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with none expected: value %0d", res_item.parsed_value);
					error_count++;
				end else begin
					oldest = expected_results.pop_front();
					if (res_item.parsed_value !== oldest.parsed_value) begin
						$error("parsed_value expected %0d got %0d",
							oldest.parsed_value, res_item.parsed_value);
						error_count++;
					end
					if (res_item.overflowed !== oldest.overflowed) begin
						$error("overflowed expected %0b got %0b",
							oldest.overflowed, res_item.overflowed);
						error_count++;
					end
					if (res_item.chars_consumed !== oldest.chars_consumed) begin
						$error("chars_consumed expected %0d got %0d",
							oldest.chars_consumed, res_item.chars_consumed);
						error_count++;
					end
				end
			end
		end
	end

endmodule

FILE: auto_base_integer_parser.f
sv/abip_pkg.sv
sv/abip_step.sv
sv/abip_out_buf.sv
sv/auto_base_integer_parser.sv
verif/auto_base_integer_parser_tb.sv
